>>> rtl/sequence_chunk_completion_tracker_assert.svh
// Assertion macros for the chunk completion tracker.
// Each macro expands to one labelled concurrent assertion, reset-qualified.
`ifndef SEQUENCE_CHUNK_COMPLETION_TRACKER_ASSERT_SVH
`define SEQUENCE_CHUNK_COMPLETION_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define SCTR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sctr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_pkg
// Shared types and codes for the chunk completion tracker.
// ----------------------------------------------------------------------------
package sctr_pkg;

    localparam int SCTR_TABLE_ENTRIES = 16;

    localparam logic       MODE_EMIT = 1'b0;
    localparam logic       MODE_REG  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic        valid;
        logic [63:0] seq;
        logic [31:0] origin;
        logic [31:0] next_num;
        logic [31:0] final_num;
        logic [31:0] seen;
    } t_entry;

    // Outcome of one entry update.
    typedef struct packed {
        logic        wr_en;
        logic        res_vld;
        logic [31:0] chunk;
        logic        last;
        logic [1:0]  status;
    } t_upd_res;

endpackage

>>> rtl/sctr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_mem
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sctr_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  sctr_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output sctr_pkg::t_entry o_rdata
);
    import sctr_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sctr_upd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_upd
// Entry update: allocate or modify one entry and form the result.
// ----------------------------------------------------------------------------
module sctr_upd (
    input  logic              i_mode,
    input  logic [63:0]       i_seq,
    input  logic [31:0]       i_origin,
    input  logic              i_ends,
    input  logic [31:0]       i_inc_num,
    input  logic              i_inc_last,
    input  logic              i_hit,
    input  logic              i_free,
    input  sctr_pkg::t_entry  i_entry,
    output sctr_pkg::t_entry  o_entry,
    output sctr_pkg::t_upd_res o_res
);
    import sctr_pkg::*;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    t_entry   ent;
    t_upd_res res;
    logic     owner;

    always_comb begin
        ent   = i_entry;
        res   = '0;
        owner = i_hit | i_free;
        // fresh entry when the key was not found
        if (!i_hit) begin
            ent.valid     = 1'b1;
            ent.seq       = i_seq;
            ent.origin    = i_origin;
            ent.next_num  = 32'd1;
            ent.final_num = 32'd0;
            ent.seen      = 32'd0;
        end
        res.wr_en = owner;
        if (i_mode == MODE_REG) begin
            ent.seen = sat_inc(ent.seen);
        end else begin
            res.res_vld = 1'b1;
            if (!owner) begin
                res.status = ST_FULL;
            end else begin
                res.chunk    = ent.next_num;
                ent.next_num = sat_inc(ent.next_num);
                if (i_ends) begin
                    if (i_inc_last) begin
                        if (ent.final_num != 32'd0) begin
                            res.status = ST_DUP;
                        end else begin
                            ent.final_num = i_inc_num;
                        end
                    end
                    ent.seen = sat_inc(ent.seen);
                    if (ent.final_num != 32'd0 && ent.seen == ent.final_num) begin
                        ent.valid = 1'b0;
                        res.last  = 1'b1;
                    end
                end
            end
        end
    end

    assign o_entry = ent;
    assign o_res   = res;

endmodule

>>> rtl/sequence_chunk_completion_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_chunk_completion_tracker
// Tracks chunk completion per (sequence, origin) key in a table held in memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | fields
//  --------+-----------+-------------------------+-------------------------------
//  command | in        | start & !busy           | mode, sequence_number, origin_id,
//          |           |                         | ends_incoming_chunk,
//          |           |                         | incoming_chunk_number,
//          |           |                         | incoming_is_last
//  result  | out       | o_valid, one-cycle pulse| chunk_number, last_chunk, status
//
//  The key search issues one read per entry and checks each in the cycle after
//  its read; the update state then writes the entry back when a matching or
//  free entry exists, and registers the result. busy stays high until an item
//  is done, so a new command waits for it. Only emit-mode items give a result;
//  its pulse lands in the cycle busy drops. After reset a clearing pass marks
//  every entry free; busy stays high during it. The receiver cannot stall the result.
`include "sequence_chunk_completion_tracker_assert.svh"

module sequence_chunk_completion_tracker #(
    parameter int TABLE_ENTRIES = sctr_pkg::SCTR_TABLE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [63:0] i_sequence_number,
    input  logic [31:0] i_origin_id,
    input  logic        i_ends_incoming_chunk,
    input  logic [31:0] i_incoming_chunk_number,
    input  logic        i_incoming_is_last,
    output logic        o_valid,
    output logic [31:0] o_chunk_number,
    output logic        o_last_chunk,
    output logic [1:0]  o_status
);
    import sctr_pkg::*;

    localparam int          IW   = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state      r_state;

    // held transaction
    logic        r_mode;
    logic [63:0] r_seq;
    logic [31:0] r_origin;
    logic        r_ends;
    logic [31:0] r_inc_num;
    logic        r_inc_last;

    // search bookkeeping
    logic [IW-1:0] r_scan_idx;
    logic          r_issue;
    logic          r_chk;
    logic [IW-1:0] r_chk_idx;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    t_entry        r_hit_entry;
    logic          r_free;
    logic [IW-1:0] r_free_idx;

    // registered result
    logic        r_valid;
    logic [31:0] r_chunk;
    logic        r_last;
    logic [1:0]  r_status;

    t_entry        rd_data;
    t_entry        upd_entry;
    t_upd_res      upd_res;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          accept;
    logic          key_match;

    assign busy   = (r_state != S_IDLE);
    assign accept = start & ~busy;

    assign key_match = rd_data.valid && (rd_data.seq == r_seq) && (rd_data.origin == r_origin);

    sctr_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_scan_idx),
        .o_rdata (rd_data)
    );

    sctr_upd u_upd (
        .i_mode     (r_mode),
        .i_seq      (r_seq),
        .i_origin   (r_origin),
        .i_ends     (r_ends),
        .i_inc_num  (r_inc_num),
        .i_inc_last (r_inc_last),
        .i_hit      (r_hit),
        .i_free     (r_free),
        .i_entry    (r_hit_entry),
        .o_entry    (upd_entry),
        .o_res      (upd_res)
    );

    // Write port: clearing sweep, or write-back of the updated entry.
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_scan_idx;
            mem_wdata = '0;
        end else begin
            mem_we    = (r_state == S_UPDATE) && upd_res.wr_en;
            mem_waddr = r_hit ? r_hit_idx : r_free_idx;
            mem_wdata = upd_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_scan_idx <= '0;
            r_issue    <= 1'b0;
            r_chk      <= 1'b0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    // sweep every entry to free
                    if (r_scan_idx == LAST_IDX) begin
                        r_scan_idx <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_mode     <= i_mode;
                        r_seq      <= i_sequence_number;
                        r_origin   <= i_origin_id;
                        r_ends     <= i_ends_incoming_chunk;
                        r_inc_num  <= i_incoming_chunk_number;
                        r_inc_last <= i_incoming_is_last;
                        r_scan_idx <= '0;
                        r_issue    <= 1'b1;
                        r_chk      <= 1'b0;
                        r_hit      <= 1'b0;
                        r_free     <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue one read per cycle
                    r_chk     <= r_issue;
                    r_chk_idx <= r_scan_idx;
                    if (r_issue) begin
                        if (r_scan_idx == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_scan_idx <= r_scan_idx + 1'b1;
                        end
                    end
                    // check the entry read in the previous cycle
                    if (r_chk) begin
                        if (key_match && !r_hit) begin
                            r_hit       <= 1'b1;
                            r_hit_idx   <= r_chk_idx;
                            r_hit_entry <= rd_data;
                        end
                        // keep the lowest free index
                        if (!rd_data.valid && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_chk_idx;
                        end
                        if (r_chk_idx == LAST_IDX) begin
                            r_state <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE: begin
                    r_valid    <= upd_res.res_vld;
                    r_chunk    <= upd_res.chunk;
                    r_last     <= upd_res.last;
                    r_status   <= upd_res.status;
                    r_scan_idx <= '0;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_chunk_number = r_chunk;
    assign o_last_chunk   = r_last;
    assign o_status       = r_status;

    `SCTR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept,
        busy && r_state == S_SCAN, "accepted transaction did not start a search")
    `SCTR_ASSERT_NOW(a_no_write_in_scan, i_clk, i_rst_n, r_state == S_SCAN,
        !mem_we, "entry memory written during search")
    `SCTR_ASSERT_NOW(a_full_result, i_clk, i_rst_n, o_valid && o_status == ST_FULL,
        o_chunk_number == 32'd0 && !o_last_chunk, "table-full result carries a chunk number")
    `SCTR_ASSERT_NOW(a_result_after_update, i_clk, i_rst_n, o_valid,
        $past(r_state) == S_UPDATE && !busy, "result strobe outside update slot")

endmodule
